// ----- src/diagonal_phase_rotation_core_defines.svh -----
// Assertion macros shared by the checker of the diagonal phase rotation core.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef DIAGONAL_PHASE_ROTATION_CORE_DEFINES_SVH
`define DIAGONAL_PHASE_ROTATION_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define DPR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpr: same-cycle check failed");

// next-cycle implication, off during reset
`define DPR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpr: next-cycle check failed");

// what must hold in the cycle after reset is seen
`define DPR_ASSERT_RST(name, cons) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("dpr: post-reset check failed");

`endif

// ----- src/dpr_pkg.sv -----
// Package of the diagonal phase rotation core: constants, control word type,
// CORDIC arctangent table. No dependencies.
`default_nettype none

package dpr_pkg;

  localparam int CORDIC_STAGES_DEF = 18;
  localparam int AMP_BITS_DEF      = 18;
  localparam int GUARD             = 8;   // extra fraction bits inside the CORDIC

  // round(2^66 / (2*pi)), split into 32-bit halves
  localparam logic [31:0] INV2PI_HI = 32'hA2F9836E;
  localparam logic [31:0] INV2PI_LO = 32'h4E44152A;

  // CORDIC gain compensation, Q0.32, split into 16-bit halves
  localparam logic [15:0] GAIN_HI = 16'h9B74;
  localparam logic [15:0] GAIN_LO = 16'hEDA8;

  typedef struct packed {
    logic valid;
    logic last;
  } dpr_ctl_t;

  // atan(2^-i) in Q0.32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      5'd24: val = 32'd41;
      5'd25: val = 32'd20;
      5'd26: val = 32'd10;
      5'd27: val = 32'd5;
      5'd28: val = 32'd3;
      5'd29: val = 32'd1;
      5'd30: val = 32'd1;
      5'd31: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- src/dpr_front.sv -----
// Phase front end: gamma*energy, reduction to turns, quadrant fold.
// Five register stages. Depends on dpr_pkg.
`default_nettype none

module dpr_front import dpr_pkg::*; #(
  parameter int AMP_BITS = AMP_BITS_DEF,
  parameter int XW       = AMP_BITS_DEF + GUARD + 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire dpr_ctl_t                   ctl_i,
  input  wire logic signed [31:0]         gamma,
  input  wire logic signed [31:0]         energy,
  input  wire logic signed [AMP_BITS-1:0] amp_real,
  input  wire logic signed [AMP_BITS-1:0] amp_imag,
  output dpr_ctl_t                        ctl_o,
  output logic signed [XW-1:0]            x_o,
  output logic signed [XW-1:0]            y_o,
  output logic signed [31:0]              z_o
);

  localparam int PAD = XW - AMP_BITS - GUARD;

  dpr_ctl_t ctl_s [1:5];

  logic signed [AMP_BITS-1:0] ar_d [1:4];
  logic signed [AMP_BITS-1:0] ai_d [1:4];

  logic signed [63:0] prod;
  logic signed [64:0] hh;
  logic signed [64:0] hl;
  logic        [63:0] lh;
  logic        [63:0] ll;
  logic        [65:0] mid;
  logic        [64:0] hh3;
  logic        [63:0] ll3;
  logic        [31:0] theta;

  logic [109:0]         acc;
  logic [31:0]          zu;
  logic                 flip;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  // product mod 2^110; bits 109..78 are the phase in turns
  assign acc = {hh3[45:0], 64'd0} + {{12{mid[65]}}, mid, 32'd0} + {46'd0, ll3};

  assign zu   = ~theta + 32'd1;
  assign flip = zu[31] ^ zu[30];   // angle in [1/4, 3/4) turn
  assign xs   = {{PAD{ar_d[4][AMP_BITS-1]}}, ar_d[4], {GUARD{1'b0}}};
  assign ys   = {{PAD{ai_d[4][AMP_BITS-1]}}, ai_d[4], {GUARD{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 5; k++) ctl_s[k].valid <= 1'b0;
    end else if (en) begin
      ctl_s[1] <= ctl_i;
      for (int k = 2; k <= 5; k++) ctl_s[k] <= ctl_s[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= gamma * energy;
      ar_d[1] <= amp_real;
      ai_d[1] <= amp_imag;
      for (int k = 2; k <= 4; k++) begin
        ar_d[k] <= ar_d[k-1];
        ai_d[k] <= ai_d[k-1];
      end
      hh    <= $signed(prod[63:32]) * $signed({1'b0, INV2PI_HI});
      hl    <= $signed(prod[63:32]) * $signed({1'b0, INV2PI_LO});
      lh    <= prod[31:0] * INV2PI_HI;
      ll    <= prod[31:0] * INV2PI_LO;
      mid   <= {hl[64], hl} + {2'b00, lh};
      hh3   <= hh;
      ll3   <= ll;
      theta <= acc[109:78];
      x_o   <= flip ? -xs : xs;
      y_o   <= flip ? -ys : ys;
      z_o   <= flip ? {~zu[31], zu[30:0]} : zu;
    end
  end

  assign ctl_o = ctl_s[5];

endmodule

`default_nettype wire

// ----- src/dpr_cell.sv -----
// One CORDIC rotation cell: shift-add micro-rotation, one register stage.
// Depends on dpr_pkg.
`default_nettype none

module dpr_cell import dpr_pkg::*; #(
  parameter int STAGE = 0,
  parameter int XW    = AMP_BITS_DEF + GUARD + 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire dpr_ctl_t             ctl_i,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic signed [XW-1:0] y_i,
  input  wire logic signed [31:0]   z_i,
  output dpr_ctl_t                  ctl_o,
  output logic signed [XW-1:0]      x_o,
  output logic signed [XW-1:0]      y_o,
  output logic signed [31:0]        z_o
);

  localparam logic [31:0] ATAN = atan_turn(5'(STAGE));

  logic signed [XW-1:0] xsh;
  logic signed [XW-1:0] ysh;

  assign xsh = x_i >>> STAGE;
  assign ysh = y_i >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[31]) begin
        x_o <= x_i - ysh;
        y_o <= y_i + xsh;
        z_o <= z_i - $signed(ATAN);
      end else begin
        x_o <= x_i + ysh;
        y_o <= y_i - xsh;
        z_o <= z_i + $signed(ATAN);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/dpr_gain.sv -----
// Gain compensation for one component: registered partial products, then
// round half up and saturate. Depends on dpr_pkg.
`default_nettype none

module dpr_gain import dpr_pkg::*; #(
  parameter int AMP_BITS = AMP_BITS_DEF,
  parameter int XW       = AMP_BITS_DEF + GUARD + 2
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [XW-1:0]  x,
  output logic signed [AMP_BITS-1:0] r
);

  localparam int MW = XW + 17;
  localparam int SW = XW + 18;
  localparam int RW = SW - 16 - GUARD;

  logic signed [MW-1:0] p_hi;
  logic signed [MW-1:0] p_lo;
  logic signed [SW-1:0] p;
  logic signed [SW-1:0] rnd;
  logic signed [RW-1:0] q;
  logic                 ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi <= x * $signed({1'b0, GAIN_HI});
      p_lo <= x * $signed({1'b0, GAIN_LO});
    end
  end

  assign p   = SW'(p_hi) + SW'(p_lo >>> 16);
  assign rnd = p + (SW'(1) <<< (15 + GUARD));
  assign q   = rnd[SW-1:16+GUARD];
  // out of range when the bits above the result are not all sign
  assign ovf = (q[RW-1:AMP_BITS-1] != {(RW-AMP_BITS+1){q[RW-1]}});

  always_comb begin
    if (ovf) begin
      r = q[RW-1] ? {1'b1, {(AMP_BITS-1){1'b0}}} : {1'b0, {(AMP_BITS-1){1'b1}}};
    end else begin
      r = q[AMP_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- src/diagonal_phase_rotation_core.sv -----
// Diagonal phase rotation core: rotates each complex amplitude by
// -gamma*energy with a pipelined chain of CORDIC cells; one word per clock.
// Depends on dpr_pkg, dpr_front, dpr_cell, dpr_gain.
//
// Takes one amplitude word (Q1.17 real/imag, Q16.16 energy, last mark) every
// clock and returns one rotated word per input, in order. A word passes
// through five front stages (gamma*energy multiply, 64x64 turn reduction
// split into 32-bit partial products over three stages, quadrant fold),
// then one cell per CORDIC stage, one gain product stage and the output
// register. The pipeline moves as one piece; a stalled output word
// sits in the output register while the pipe keeps running, the next
// finished word lands in a one-word skid register, and only when that skid
// holds a word is in_stall raised. Sustained rate is one word per cycle when
// out_stall is low. gamma is written through cfg_write/cfg_data and must
// only change while no word is in flight.
`default_nettype none

module diagonal_phase_rotation_core import dpr_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int AMP_BITS      = AMP_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration: gamma, Q4.28 radians
  input  wire logic                       cfg_write,
  input  wire logic [31:0]                cfg_data,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [AMP_BITS-1:0] amp_real,
  input  wire logic signed [AMP_BITS-1:0] amp_imag,
  input  wire logic signed [31:0]         energy,
  input  wire logic                       last_amp,
  // output channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [AMP_BITS-1:0]      rot_real,
  output logic signed [AMP_BITS-1:0]      rot_imag,
  output logic                            last_out
);

  // CORDIC datapath width: guard bits plus headroom for fold and CORDIC growth
  localparam int XW = AMP_BITS + GUARD + 2;

  logic signed [31:0] gamma;

  logic     en;          // whole pipe advances
  dpr_ctl_t in_ctl;

  dpr_ctl_t             ctl [0:CORDIC_STAGES];
  logic signed [XW-1:0] x   [0:CORDIC_STAGES];
  logic signed [XW-1:0] y   [0:CORDIC_STAGES];
  logic signed [31:0]   z   [0:CORDIC_STAGES];

  dpr_ctl_t                   g_ctl;
  logic signed [AMP_BITS-1:0] g_real;
  logic signed [AMP_BITS-1:0] g_imag;
  logic                       pipe_word;

  // skid word
  logic                       skid_valid;
  logic signed [AMP_BITS-1:0] skid_real;
  logic signed [AMP_BITS-1:0] skid_imag;
  logic                       skid_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= '0;
    end else if (cfg_write) begin
      gamma <= cfg_data;
    end
  end

  // skid_valid is a register, so in_stall never waits on out_stall
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  assign in_ctl.valid = in_valid;
  assign in_ctl.last  = last_amp;

  dpr_front #(
    .AMP_BITS (AMP_BITS),
    .XW       (XW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_i    (in_ctl),
    .gamma    (gamma),
    .energy   (energy),
    .amp_real (amp_real),
    .amp_imag (amp_imag),
    .ctl_o    (ctl[0]),
    .x_o      (x[0]),
    .y_o      (y[0]),
    .z_o      (z[0])
  );

  // rotation chain: cell i applies the 2^-i micro-rotation
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    dpr_cell #(
      .STAGE (i),
      .XW    (XW)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .ctl_i (ctl[i]),
      .x_i   (x[i]),
      .y_i   (y[i]),
      .z_i   (z[i]),
      .ctl_o (ctl[i+1]),
      .x_o   (x[i+1]),
      .y_o   (y[i+1]),
      .z_o   (z[i+1])
    );
  end

  // residual angle of the last cell is not needed
  always_ff @(posedge clk) begin
    if (rst) begin
      g_ctl.valid <= 1'b0;
    end else if (en) begin
      g_ctl.valid <= ctl[CORDIC_STAGES].valid;
      g_ctl.last  <= ctl[CORDIC_STAGES].last;
    end
  end

  dpr_gain #(
    .AMP_BITS (AMP_BITS),
    .XW       (XW)
  ) u_gain_re (
    .clk (clk),
    .en  (en),
    .x   (x[CORDIC_STAGES]),
    .r   (g_real)
  );

  dpr_gain #(
    .AMP_BITS (AMP_BITS),
    .XW       (XW)
  ) u_gain_im (
    .clk (clk),
    .en  (en),
    .x   (y[CORDIC_STAGES]),
    .r   (g_imag)
  );

  // a finished word leaves the pipe this cycle
  assign pipe_word = en && g_ctl.valid;

  // output register plus skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
        rot_real   <= skid_real;
        rot_imag   <= skid_imag;
        last_out   <= skid_last;
      end else if (pipe_word) begin
        out_valid <= 1'b1;
        rot_real  <= g_real;
        rot_imag  <= g_imag;
        last_out  <= g_ctl.last;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (pipe_word) begin
      skid_valid <= 1'b1;
      skid_real  <= g_real;
      skid_imag  <= g_imag;
      skid_last  <= g_ctl.last;
    end
  end

endmodule

`default_nettype wire

// ----- src/dpr_checker.sv -----
// Port-level checker for diagonal_phase_rotation_core, attached by bind.
// Depends on dpr_pkg and diagonal_phase_rotation_core_defines.svh.
`default_nettype none
`include "diagonal_phase_rotation_core_defines.svh"

module dpr_checker import dpr_pkg::*; #(
  parameter int AMP_BITS = AMP_BITS_DEF
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [AMP_BITS-1:0] rot_real,
  input wire logic [AMP_BITS-1:0] rot_imag,
  input wire logic                last_out
);

  // nothing comes out and the input is not stalled right after reset
  `DPR_ASSERT_RST(a_rst_empty, !out_valid && !in_stall)

  // input back-pressure only after the output side was blocked
  `DPR_ASSERT_IMP(a_stall_cause, in_stall, $past(out_valid && out_stall))

  // an unblocked output frees the input in the next cycle
  `DPR_ASSERT_NXT(a_stall_release, !out_stall, !in_stall)

  // a stalled output word holds
  `DPR_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(rot_real) && $stable(rot_imag) && $stable(last_out))

endmodule

bind diagonal_phase_rotation_core dpr_checker #(.AMP_BITS(AMP_BITS)) u_dpr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .rot_real  (rot_real),
  .rot_imag  (rot_imag),
  .last_out  (last_out)
);

`default_nettype wire

// ----- dv/diagonal_phase_rotation_core_tb.sv -----
// Self-checking testbench for diagonal_phase_rotation_core: random and directed amplitude words,
// with each rotated word checked against a fixed-point rotation computed inside the bench.
// Depends on dpr_pkg and the diagonal_phase_rotation_core RTL.
`timescale 1ns / 100ps

module diagonal_phase_rotation_core_tb;
  import dpr_pkg::*;

  localparam int STAGES   = CORDIC_STAGES_DEF;
  localparam int AMP_BITS = AMP_BITS_DEF;
  localparam int LATENCY  = STAGES + 7;   // front, cells, gain, output register
  localparam int MAX_GAP  = 18;

  localparam logic signed [AMP_BITS-1:0] AMP_TOP = {1'b0, {(AMP_BITS-1){1'b1}}};
  localparam logic signed [AMP_BITS-1:0] AMP_BOT = {1'b1, {(AMP_BITS-1){1'b0}}};
  localparam longint AMP_MAX = (longint'(1) <<< (AMP_BITS - 1)) - 1;
  localparam longint AMP_MIN = -(longint'(1) <<< (AMP_BITS - 1));

  // gamma of one radian per unit energy, Q4.28
  localparam logic [31:0] GAMMA_ONE_RAD = 32'h1000_0000;
  // energies in Q16.16 that land near quarter, eighth, half and three-quarter turns at one radian
  localparam int E_EIGHTH  = 51472;
  localparam int E_QUARTER = 102944;
  localparam int E_HALF    = 205887;
  localparam int E_3QUART  = 308831;

  // atan(2^-i) in Q0.32 turns
  localparam longint ATAN_TURNS [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef struct {
    logic signed [AMP_BITS-1:0] re;
    logic signed [AMP_BITS-1:0] im;
    logic signed [31:0]         energy;
    logic                       last;
  } amp_word_t;

  typedef struct {
    logic signed [AMP_BITS-1:0] re;
    logic signed [AMP_BITS-1:0] im;
    logic                       last;
  } rot_word_t;

  // Holds the rotated words still owed by the block, in input order, and
  // the gamma they were computed with.
  class rotation_tally;
    rot_word_t          pending_rotations[$];
    logic signed [31:0] gamma_q;
    int                 errors;
    int                 matched;

    function new();
      gamma_q = '0;
      errors  = 0;
      matched = 0;
    endfunction

    // gain compensation as a split 16-bit product, round half up, clip
    function longint scale_and_clip(longint v);
      longint p;
      longint r;
      p = v * longint'(GAIN_HI) + ((v * longint'(GAIN_LO)) >>> 16);
      r = (p + (longint'(1) <<< (15 + GUARD))) >>> (16 + GUARD);
      if (r > AMP_MAX) r = AMP_MAX;
      if (r < AMP_MIN) r = AMP_MIN;
      return r;
    endfunction

    // rotate by -gamma*energy, angle reduced to one turn
    function rot_word_t rotate_by_phase(amp_word_t a);
      longint        gl, el, angle, x, y, z, xn, yn, clipped;
      logic [127:0]  wide;
      logic [31:0]   zu;
      rot_word_t     r;
      gl    = gamma_q;
      el    = a.energy;
      angle = gl * el;                              // Q20.44 radians, exact
      wide  = {{64{angle[63]}}, angle} * {64'd0, INV2PI_HI, INV2PI_LO};
      zu    = 32'd0 - wide[109:78];                 // minus theta, Q0.32 turns
      x = a.re;
      y = a.im;
      x = x * (longint'(1) <<< GUARD);
      y = y * (longint'(1) <<< GUARD);
      // fold the left half plane onto the right one
      if (zu >= 32'h4000_0000 && zu < 32'hC000_0000) begin
        x  = -x;
        y  = -y;
        zu = zu - 32'h8000_0000;
      end
      z = $signed(zu);
      for (int i = 0; i < STAGES && i < 32; i++) begin
        if (z >= 0) begin
          xn = x - (y >>> i);
          yn = y + (x >>> i);
          z  = z - ATAN_TURNS[i];
        end else begin
          xn = x + (y >>> i);
          yn = y - (x >>> i);
          z  = z + ATAN_TURNS[i];
        end
        x = xn;
        y = yn;
      end
      clipped = scale_and_clip(x);
      r.re    = clipped[AMP_BITS-1:0];
      clipped = scale_and_clip(y);
      r.im    = clipped[AMP_BITS-1:0];
      r.last  = a.last;
      return r;
    endfunction

    function void take_amplitude(amp_word_t a);
      pending_rotations = {pending_rotations, rotate_by_phase(a)};
    endfunction

    function void flag(string what, longint want, longint got);
      errors++;
      $error("%s: expected %0d, actual %0d", what, want, got);
    endfunction

    function void match_rotation(rot_word_t got);
      rot_word_t want;
      if (pending_rotations.size() == 0) begin
        errors++;
        $error("rotated word with no amplitude outstanding: real %0d imag %0d last %0b",
               got.re, got.im, got.last);
        return;
      end
      want = pending_rotations.pop_front();
      matched++;
      if (got.re !== want.re)     flag("rot_real", want.re, got.re);
      if (got.im !== want.im)     flag("rot_imag", want.im, got.im);
      if (got.last !== want.last) flag("last_out", want.last, got.last);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [31:0]                cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [AMP_BITS-1:0] amp_real;
  logic signed [AMP_BITS-1:0] amp_imag;
  logic signed [31:0]         energy;
  logic                       last_amp;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [AMP_BITS-1:0] rot_real;
  logic signed [AMP_BITS-1:0] rot_imag;
  logic                       last_out;

  rotation_tally tally = new();

  // sender pacing: calm stretches send back to back, rush forces it
  int send_calm_left = 0;
  bit send_calm      = 1'b0;
  bit send_rush      = 1'b0;
  // receiver pacing: a nonzero hold sets the length of one long sink stall
  int sink_hold      = 0;
  bit sink_calm      = 1'b0;

  int words_sent     = 0;
  int gamma_settings = 0;

  diagonal_phase_rotation_core #(
    .CORDIC_STAGES(STAGES),
    .AMP_BITS     (AMP_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .amp_real (amp_real),
    .amp_imag (amp_imag),
    .energy   (energy),
    .last_amp (last_amp),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rot_real (rot_real),
    .rot_imag (rot_imag),
    .last_out (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every word waiting out the
  // longest gap on both sides, plus the long hold and the drains).
  initial begin
    #5_000_000;
    $display("diagonal_phase_rotation_core verification failed");
    $finish;
  end

  // Result monitor. Everything the DUT drives changes through its own
  // registers, so the values seen here are the ones before this edge.
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      tally.match_rotation(rot_word_t'{rot_real, rot_imag, last_out});
  end

  // Result sink: draws a stall per word, with calm stretches and, when
  // asked, one long hold so the pipeline backs up into in_stall.
  initial begin : result_sink
    int wait_cycles;
    int calm_left;
    calm_left = 0;
    out_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (calm_left == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(20, 80);
      end
      calm_left--;
      if (sink_hold > 0) begin
        out_stall <= 1'b1;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else begin
        wait_cycles = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic amp_word_t make_amp(input int re, input int im, input int en,
                                         input bit last);
    amp_word_t w;
    w.re     = re[AMP_BITS-1:0];
    w.im     = im[AMP_BITS-1:0];
    w.energy = en;
    w.last   = last;
    return w;
  endfunction

  function automatic logic signed [AMP_BITS-1:0] random_part();
    logic [31:0]                r;
    logic signed [AMP_BITS-1:0] v;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: v = r[0] ? AMP_TOP : AMP_BOT;
      1: v = $signed(r[9:0]);                   // near zero, both signs
      default: v = r[AMP_BITS-1:0];
    endcase
    return v;
  endfunction

  function automatic amp_word_t random_amplitude(input bit last);
    amp_word_t   w;
    logic [31:0] r;
    r = $urandom();
    w.re = random_part();
    w.im = random_part();
    case ($urandom_range(0, 7))
      0: begin
        case (r[2:0])
          3'd0:    w.energy = 32'h7FFF_FFFF;
          3'd1:    w.energy = 32'h8000_0000;
          3'd2:    w.energy = 32'h0000_0000;
          3'd3:    w.energy = 32'hFFFF_FFFF;
          default: w.energy = 32'h0000_0001;
        endcase
      end
      1, 2: w.energy = $signed(r[21:0]);        // under 32 units of energy, either sign
      default: w.energy = r;
    endcase
    w.last = last;
    return w;
  endfunction

  // Offer one word and hold it until accepted. A word that follows with no
  // gap is loaded at the accepting edge, so valid stays high without a dip.
  task automatic send_amplitude(input amp_word_t w);
    int gap;
    if (send_calm_left == 0) begin
      send_calm      = ($urandom_range(0, 3) == 0);
      send_calm_left = $urandom_range(20, 60);
    end
    send_calm_left--;
    gap = (send_calm || send_rush) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    amp_real <= w.re;
    amp_imag <= w.im;
    energy   <= w.energy;
    last_amp <= w.last;
    do @(posedge clk); while (in_stall !== 1'b0);
    tally.take_amplitude(w);
    words_sent++;
  endtask

  // Stop offering and wait until every owed rotated word has come back.
  task automatic drain_rotations();
    in_valid <= 1'b0;
    while (tally.pending_rotations.size() != 0) @(posedge clk);
  endtask

  // gamma only moves while nothing is in flight
  task automatic set_gamma(input logic [31:0] value);
    drain_rotations();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    tally.gamma_q = value;
    gamma_settings++;
  endtask

  // Vectors of 1 to 16 amplitudes, last set on the final one; now and then
  // the mark is flipped, and now and then the sender waits for a full drain.
  task automatic run_vectors(input int count);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 16);
      if (len > left) len = left;
      for (int k = 0; k < len; k++)
        send_amplitude(random_amplitude((k == len - 1) ^ ($urandom_range(0, 19) == 0)));
      left -= len;
      if ($urandom_range(0, 24) == 0) drain_rotations();
    end
  endtask

  initial begin : stimulus
    logic [31:0] g;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    amp_real  <= '0;
    amp_imag  <= '0;
    energy    <= '0;
    last_amp  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gamma still at its reset value of zero: rotation by nothing, so only
    // rounding and clipping of the gain stage show; amplitude corners
    send_amplitude(make_amp(AMP_TOP, AMP_TOP, 0, 1'b0));
    send_amplitude(make_amp(AMP_BOT, AMP_BOT, 0, 1'b1));
    send_amplitude(make_amp(AMP_TOP, AMP_BOT, 32'h7FFF_FFFF, 1'b0));
    send_amplitude(make_amp(0, 0, 32'h8000_0000, 1'b1));
    send_amplitude(make_amp(1, -1, 1, 1'b0));

    // one radian per unit energy: straddle the fold at a quarter turn
    // either way, the half and three-quarter turn, and the 45 degree cases
    // where full-scale amplitudes clip
    set_gamma(GAMMA_ONE_RAD);
    send_amplitude(make_amp(100000, -50000, 0, 1'b0));
    send_amplitude(make_amp(100000, -50000, E_QUARTER, 1'b0));
    send_amplitude(make_amp(100000, -50000, E_QUARTER - 1, 1'b0));
    send_amplitude(make_amp(-70000, 90000, -E_QUARTER, 1'b0));
    send_amplitude(make_amp(-70000, 90000, -(E_QUARTER - 1), 1'b0));
    send_amplitude(make_amp(AMP_TOP, 12345, E_HALF, 1'b0));
    send_amplitude(make_amp(AMP_BOT, -12345, E_3QUART, 1'b0));
    send_amplitude(make_amp(AMP_TOP, AMP_TOP, -E_EIGHTH, 1'b0));
    send_amplitude(make_amp(AMP_BOT, AMP_BOT, -E_EIGHTH, 1'b0));
    send_amplitude(make_amp(AMP_TOP, AMP_BOT, E_EIGHTH, 1'b0));
    send_amplitude(make_amp(40000, 40000, 32'h7FFF_FFFF, 1'b0));
    send_amplitude(make_amp(-40000, 40000, 32'h8000_0000, 1'b1));

    // largest phase per unit energy, both signs, against the energy extremes
    set_gamma(32'h7FFF_FFFF);
    send_amplitude(make_amp(AMP_TOP, AMP_BOT, 32'h7FFF_FFFF, 1'b0));
    send_amplitude(make_amp(AMP_BOT, AMP_TOP, 32'h8000_0000, 1'b1));
    set_gamma(32'h8000_0000);
    send_amplitude(make_amp(AMP_TOP, AMP_TOP, 32'h8000_0000, 1'b0));
    send_amplitude(make_amp(AMP_BOT, 1, 32'h7FFF_FFFF, 1'b1));

    // random vectors under the extreme gammas
    set_gamma(32'h7FFF_FFFF);
    run_vectors(100);
    set_gamma(32'h8000_0000);
    run_vectors(100);

    // backpressure: sink holds for a long stretch while words keep coming,
    // which fills the pipe and the skid word and raises in_stall
    set_gamma(GAMMA_ONE_RAD);
    sink_hold = 300;
    send_rush = 1'b1;
    for (int n = 0; n < 64; n++) send_amplitude(random_amplitude(n % 8 == 7));
    send_rush = 1'b0;

    // random full-range and small gammas
    for (int n = 0; n < 4; n++) begin
      set_gamma($urandom());
      run_vectors(100);
    end
    g = $urandom();
    set_gamma({{10{g[31]}}, g[21:0]});
    run_vectors(100);
    set_gamma(32'h0000_0000);
    run_vectors(60);

    drain_rotations();
    repeat (LATENCY + 8) @(posedge clk);
    $display("run covered %0d amplitude words over %0d gamma settings;",
             words_sent, gamma_settings + 1);
    $display("%0d rotated words compared, including a long output hold",
             tally.matched);
    if (tally.errors == 0 && tally.pending_rotations.size() == 0) begin
      $display("diagonal_phase_rotation_core verification clean");
    end else begin
      $display("diagonal_phase_rotation_core verification failed");
    end
    $finish;
  end

endmodule
